FILE: sv/rcf_pkg.sv
package rcf_pkg;

  localparam int PIX_W  = 24;
  localparam int COEF_W = 20;
  localparam int ACC_W  = 34;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [PIX_W-1:0] pix_t;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KTOP   = 3'd2;
  localparam logic [2:0] REG_KMID   = 3'd3;
  localparam logic [2:0] REG_KBOT   = 3'd4;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
    logic [8:0] tap_en;
  } job_t;

  function automatic logic [7:0] clamp_sum(input logic signed [ACC_W-1:0] s);
    logic [7:0] r;
    if (s < 0) r = 8'd0;
    else if (s >= ACC_W'(255 * 4096)) r = 8'd255;
    else r = s[19:12];
    return r;
  endfunction

endpackage

FILE: sv/rcf_window.sv
module rcf_window import rcf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] image_width,
  input  logic [10:0] image_height,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        job_valid,
  input  logic        job_take,
  output job_t        job,
  output pix_t        win [9]
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  pix_t mem_near [MAX_WIDTH];
  pix_t mem_far  [MAX_WIDTH];
  pix_t rd_near, rd_far;

  // Stage 1 registers: accepted pixel waits for the line-store read.
  logic        s1_valid;
  pix_t        s1_cur;
  logic [WW:0] s1_c;
  logic [HW:0] s1_r;
  logic        s1_row_end, s1_last_row;
  logic [AW-1:0] s1_idx;

  logic [WW:0] col_count;
  logic [HW:0] row_count;
  logic [WW:0] w_eff;
  logic [HW:0] h_eff;

  // Pending results of the most recent step, drained one per cycle while job_take is high.
  logic [3:0]  pend;
  logic [WW:0] p_c;
  logic [HW:0] p_r;
  logic [WW:0] p_w;
  logic [HW:0] p_h;
  pix_t        wreg [9];

  logic accept, adv;
  logic [AW-1:0] idx;
  logic row_end, last_row;
  pix_t cur;

  always_comb begin
    if (image_width == 11'd0) w_eff = (WW+1)'(1);
    else if (int'(image_width) > MAX_WIDTH) w_eff = (WW+1)'(MAX_WIDTH);
    else w_eff = (WW+1)'(image_width);
    if (image_height == 11'd0) h_eff = (HW+1)'(1);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = (HW+1)'(MAX_HEIGHT);
    else h_eff = (HW+1)'(image_height);
  end

  assign idx = AW'(col_count);
  assign row_end = col_count >= w_eff - 1'b1;
  assign last_row = row_count >= h_eff - 1'b1;
  assign cur = {blue_in, green_in, red_in};

  // Step advances when stage 1 holds an item and no results are left pending.
  assign adv = s1_valid && (pend == 4'd0);
  assign in_stall = s1_valid && !adv;
  assign accept = in_valid && !in_stall;

  // Same-index hazard: with a one-pixel row the next pixel reads mem_far at
  // the entry that the current step writes back in the same cycle, so that
  // read takes the value being written.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_near <= mem_near[idx];
      rd_far  <= (adv && (s1_idx == idx)) ? rd_near : mem_far[idx];
      mem_near[idx] <= cur;
    end
    if (s1_valid && adv) mem_far[s1_idx] <= rd_near;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (row_end) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1_cur <= cur;
      s1_c <= col_count;
      s1_r <= row_count;
      s1_row_end <= row_end;
      s1_last_row <= last_row;
      s1_idx <= idx;
      p_w <= w_eff;
      p_h <= h_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      for (int i = 0; i < 9; i++) wreg[i] <= '0;
    end else begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          wreg[3*i]   <= wreg[3*i+1];
          wreg[3*i+1] <= wreg[3*i+2];
        end
        wreg[2] <= (s1_r >= 2) ? rd_far : '0;
        wreg[5] <= (s1_r >= 1) ? rd_near : '0;
        wreg[8] <= s1_cur;
        pend <= {s1_last_row && s1_row_end, s1_last_row && (s1_c >= 1),
                 (s1_r >= 1) && s1_row_end, (s1_r >= 1) && (s1_c >= 1)};
        p_c <= s1_c;
        p_r <= s1_r;
      end else if (job_valid && job_take) begin
        if (pend[0]) pend[0] <= 1'b0;
        else if (pend[1]) pend[1] <= 1'b0;
        else if (pend[2]) pend[2] <= 1'b0;
        else pend[3] <= 1'b0;
      end
    end
  end

  logic [1:0] sel;
  logic cx2, cy2;
  logic signed [WW+2:0] x;
  logic signed [HW+2:0] y;

  always_comb begin
    if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
    cx2 = sel[0];
    cy2 = sel[1];
    x = cx2 ? (WW+3)'(p_c) : (WW+3)'(p_c) - 1'b1;
    y = cy2 ? (HW+3)'(p_r) : (HW+3)'(p_r) - 1'b1;
    job_valid = pend != 4'd0;
    job.col = 10'(x);
    job.row = 10'(y);
    case (sel)
      2'd0: job.last = pend[3:1] == 3'd0;
      2'd1: job.last = pend[3:2] == 2'd0;
      2'd2: job.last = !pend[3];
      default: job.last = 1'b1;
    endcase
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        logic signed [WW+3:0] px;
        logic signed [HW+3:0] py;
        logic inw;
        px = (WW+4)'(x) + (WW+4)'(dx) - (WW+4)'(1);
        py = (HW+4)'(y) + (HW+4)'(dy) - (HW+4)'(1);
        inw = (cx2 ? (dx < 2) : 1'b1) && (cy2 ? (dy < 2) : 1'b1);
        job.tap_en[3*dy+dx] = inw && px >= 0 && px < (WW+4)'(p_w)
                              && py >= 0 && py < (HW+4)'(p_h);
        win[3*dy+dx] = wreg[3*(dy + (cy2 ? 1 : 0)) + dx + (cx2 ? 1 : 0) > 8 ? 8 :
                            3*(dy + (cy2 ? 1 : 0)) + dx + (cx2 ? 1 : 0)];
      end
    end
  end

endmodule

FILE: sv/rcf_mac.sv
module rcf_mac import rcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [59:0] kernel_row_top,
  input  logic [59:0] kernel_row_middle,
  input  logic [59:0] kernel_row_bottom,
  input  logic        job_valid,
  output logic        job_take,
  input  job_t        job,
  input  pix_t        win [9],
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic        run_last
);

  logic s_valid;
  logic signed [ACC_W-1:0] prod [3][9];
  logic signed [ACC_W-1:0] acc [3];
  job_t s_job;
  logic s_take;
  coef_t k [9];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k[i]   = kernel_row_top[20*i +: 20];
      k[3+i] = kernel_row_middle[20*i +: 20];
      k[6+i] = kernel_row_bottom[20*i +: 20];
    end
  end

  assign s_take = !s_valid || !out_valid || !out_stall;
  assign job_take = s_take;

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (s_take) s_valid <= job_valid;
    if (s_take && job_valid) begin
      s_job <= job;
      for (int c = 0; c < 3; c++)
        for (int t = 0; t < 9; t++)
          prod[c][t] <= job.tap_en[t] ?
            ACC_W'($signed({1'b0, win[t][8*c +: 8]})) * ACC_W'(k[t]) : '0;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = '0;
      for (int t = 0; t < 9; t++) acc[c] = acc[c] + prod[c][t];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!out_valid || !out_stall) out_valid <= s_valid;
    if (s_valid && (!out_valid || !out_stall)) begin
      red_out <= clamp_sum(acc[0]);
      green_out <= clamp_sum(acc[1]);
      blue_out <= clamp_sum(acc[2]);
      out_col <= s_job.col;
      out_row <= s_job.row;
      run_last <= s_job.last;
    end
  end

endmodule

FILE: sv/rgb_conv3x3_filter.sv
// RGB 3x3 convolution with zero padding over a raster pixel stream. Each
// input transfer may cause up to four output transfers (at row ends and in
// the last row). A pixel that causes no result does not hold up the next
// one, but the next pixel waits until the results of the current one have
// been handed on, and output stalls hold it further. Two line stores in block
// memory hold the previous two rows; a pixel passes the stage 1 registers,
// the window registers and pending flags, the product registers and the
// output registers before its first result appears on the outputs.
module rgb_conv3x3_filter import rcf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic        run_last
);

  logic [10:0] image_width, image_height;
  logic [59:0] kernel_row_top, kernel_row_middle, kernel_row_bottom;
  logic job_valid, job_take;
  job_t job;
  pix_t win [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      image_height <= 11'd1024;
      kernel_row_top <= '0;
      kernel_row_middle <= 60'h1_0000_0000;
      kernel_row_bottom <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH: image_width <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data[10:0];
        REG_KTOP: kernel_row_top <= cfg_data;
        REG_KMID: kernel_row_middle <= cfg_data;
        REG_KBOT: kernel_row_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  rcf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
    .clk, .rst, .image_width, .image_height, .in_valid, .in_stall,
    .red_in, .green_in, .blue_in, .job_valid, .job_take, .job, .win
  );

  rcf_mac u_mac (
    .clk, .rst, .kernel_row_top, .kernel_row_middle, .kernel_row_bottom,
    .job_valid, .job_take, .job, .win, .out_valid, .out_stall,
    .red_out, .green_out, .blue_out, .out_col, .out_row, .run_last
  );

endmodule

FILE: tb/rgb_conv3x3_filter_tb.sv
`timescale 1ns / 1ps

module rgb_conv3x3_filter_tb;
  import rcf_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int CYCLE_LIMIT = 700000;
  localparam int SETTLE = 10;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
  } pixel_res_t;

  typedef struct {
    int         phase;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         typed;
    logic [7:0] ered;
    logic [7:0] egreen;
    logic [7:0] eblue;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_WIDTH;
  logic [59:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  red_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  blue_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [9:0]  out_col;
  logic [9:0]  out_row;
  logic        run_last;

  rgb_conv3x3_filter dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .out_col(out_col), .out_row(out_row), .run_last(run_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Filter state mirrored by the testbench.
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [59:0] kernel_reg [3];
  pix_t        near_row [MAXW];
  pix_t        far_row [MAXW];
  pix_t        win [3][3];
  int          cur_col;
  int          cur_row;

  pixel_res_t  expected_q [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          n_frames = 0;
  int          n_shrinks = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          rx_wait = 0;

  function automatic int eff_size(logic [10:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] saturate(longint s);
    if (s < 0) return 8'd0;
    if (s >= 255 * 4096) return 8'd255;
    return 8'(s >>> 12);
  endfunction

  function automatic pixel_res_t filter_at(int cx, int cy, int x, int y, int w, int h);
    pixel_res_t res;
    longint acc [3];
    coef_t k;
    pix_t p;
    acc = '{0, 0, 0};
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (cy + dy < 0 || cy + dy > 2 || cx + dx < 0 || cx + dx > 2) continue;
        if (x + dx < 0 || x + dx >= w || y + dy < 0 || y + dy >= h) continue;
        p = win[cy + dy][cx + dx];
        k = kernel_reg[dy + 1][COEF_W * (dx + 1) +: COEF_W];
        for (int ch = 0; ch < 3; ch++) acc[ch] += longint'(p[8 * ch +: 8]) * longint'(k);
      end
    end
    res.red = saturate(acc[0]);
    res.green = saturate(acc[1]);
    res.blue = saturate(acc[2]);
    res.col = 10'(x);
    res.row = 10'(y);
    res.last = 1'b0;
    return res;
  endfunction

  function automatic int predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, h, idx, n;
    pix_t cur, nearv, farv;
    bit row_end, last_row;
    pixel_res_t res [4];
    w = eff_size(width_reg, MAXW);
    h = eff_size(height_reg, MAXH);
    idx = cur_col % MAXW;
    cur = {b, g, r};
    nearv = (cur_row >= 1) ? near_row[idx] : '0;
    farv = (cur_row >= 2) ? far_row[idx] : '0;
    row_end = cur_col >= w - 1;
    last_row = cur_row >= h - 1;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = farv;
    win[1][2] = nearv;
    win[2][2] = cur;
    far_row[idx] = near_row[idx];
    near_row[idx] = cur;
    if (cur_row >= 1) begin
      if (cur_col >= 1) res[n++] = filter_at(1, 1, cur_col - 1, cur_row - 1, w, h);
      if (row_end) res[n++] = filter_at(2, 1, cur_col, cur_row - 1, w, h);
    end
    if (last_row) begin
      if (cur_col >= 1) res[n++] = filter_at(1, 2, cur_col - 1, cur_row, w, h);
      if (row_end) res[n++] = filter_at(2, 2, cur_col, cur_row, w, h);
    end
    if (n > 0) res[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
    if (row_end) begin
      cur_col = 0;
      cur_row = last_row ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
    return n;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [59:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = value[10:0];
      REG_HEIGHT: height_reg = value[10:0];
      REG_KTOP:   kernel_reg[0] = value;
      REG_KMID:   kernel_reg[1] = value;
      REG_KBOT:   kernel_reg[2] = value;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            bit typed, pixel_res_t typed_res);
    int gap;
    int n;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (in_stall);
    n = predict_pixel(r, g, b);
    if (typed) begin
      repeat (n) void'(expected_q.pop_back());
      expected_q.push_back(typed_res);
    end
    n_items++;
  endtask

  function automatic logic [59:0] random_kernel_row();
    logic [59:0] v;
    case ($urandom_range(0, 3))
      0: v = 60'({$urandom, $urandom});
      1: begin
        for (int i = 0; i < 3; i++) v[COEF_W * i +: COEF_W] = COEF_W'($urandom_range(0, 4096));
      end
      2: begin
        for (int i = 0; i < 3; i++)
          v[COEF_W * i +: COEF_W] = COEF_W'($urandom_range(0, 8192)) - COEF_W'(2048);
      end
      default: v = {COEF_W'(0), COEF_W'($urandom_range(0, 8192)), COEF_W'(0)};
    endcase
    return v;
  endfunction

  task automatic setup_phase(int phase);
    case (phase)
      0: begin
        write_reg(REG_WIDTH, 60'd1);
        write_reg(REG_HEIGHT, 60'd1);
      end
      1: write_reg(REG_KMID, {COEF_W'(0), COEF_W'(20'h80000), COEF_W'(0)});
      2: write_reg(REG_KMID, {COEF_W'(0), COEF_W'(20'h7FFFF), COEF_W'(0)});
      3: begin
        write_reg(REG_WIDTH, 60'd3);
        write_reg(REG_HEIGHT, 60'd3);
        write_reg(REG_KTOP, {3{COEF_W'(20'h001C7)}});
        write_reg(REG_KMID, {3{COEF_W'(20'h001C7)}});
        write_reg(REG_KBOT, {3{COEF_W'(20'h001C7)}});
      end
      default: begin
        write_reg(REG_WIDTH, 60'd2);
        write_reg(REG_HEIGHT, 60'd2);
        write_reg(REG_KTOP, {COEF_W'(20'h80000), COEF_W'(20'h7FFFF), COEF_W'(20'h00800)});
        write_reg(REG_KMID, {COEF_W'(20'h01000), COEF_W'(20'hFF000), COEF_W'(20'h02000)});
        write_reg(REG_KBOT, {COEF_W'(20'h00400), COEF_W'(20'h00000), COEF_W'(20'hFFFFF)});
      end
    endcase
  endtask

  stim_row_t directed [] = '{
    '{0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
    '{0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
    '{0, 8'd128, 8'd1,   8'd254, 1'b1, 8'd128, 8'd1,   8'd254},
    '{0, 8'd85,  8'd170, 8'd15,  1'b1, 8'd85,  8'd170, 8'd15},
    '{1, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd0},
    '{2, 8'd1,   8'd2,   8'd0,   1'b1, 8'd127, 8'd255, 8'd0},
    '{3, 8'd255, 8'd0,   8'd10,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd255, 8'd0,   8'd20,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd255, 8'd0,   8'd30,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd255, 8'd255, 8'd40,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd255, 8'd255, 8'd50,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd255, 8'd255, 8'd60,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd0,   8'd128, 8'd70,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd0,   8'd128, 8'd80,  1'b0, 8'd0, 8'd0, 8'd0},
    '{3, 8'd0,   8'd128, 8'd90,  1'b0, 8'd0, 8'd0, 8'd0},
    '{4, 8'd255, 8'd0,   8'd255, 1'b0, 8'd0, 8'd0, 8'd0},
    '{4, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0, 8'd0, 8'd0},
    '{4, 8'd255, 8'd255, 8'd1,   1'b0, 8'd0, 8'd0, 8'd0},
    '{4, 8'd7,   8'd0,   8'd255, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  task automatic report_mismatch(string what, int got, int want);
    $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_res_t e;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer at column", out_col, -1);
      end else begin
        e = expected_q.pop_front();
        if (red_out !== e.red) report_mismatch("red_out", red_out, e.red);
        if (green_out !== e.green) report_mismatch("green_out", green_out, e.green);
        if (blue_out !== e.blue) report_mismatch("blue_out", blue_out, e.blue);
        if (out_col !== e.col) report_mismatch("out_col", out_col, e.col);
        if (out_row !== e.row) report_mismatch("out_row", out_row, e.row);
        if (run_last !== e.last) report_mismatch("run_last", run_last, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) rx_wait = quiet ? 0 : $urandom_range(0, 7);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        rx_wait = 300;
      end
      out_stall <= (rx_wait > 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    pixel_res_t typed_res;
    int prev_phase;
    int rand_items;
    int w;
    int in_frame;
    width_reg = 11'd1024;
    height_reg = 11'd1024;
    kernel_reg[0] = '0;
    kernel_reg[1] = 60'h0_0001_0000_0000;
    kernel_reg[2] = '0;
    win = '{default: '0};
    cur_col = 0;
    cur_row = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    prev_phase = -1;
    foreach (directed[i]) begin
      if (directed[i].phase != prev_phase) begin
        drain();
        setup_phase(directed[i].phase);
        prev_phase = directed[i].phase;
      end
      typed_res = '{directed[i].ered, directed[i].egreen, directed[i].eblue,
                    10'd0, 10'd0, 1'b1};
      send_pixel(directed[i].red, directed[i].green, directed[i].blue,
                 directed[i].typed, typed_res);
    end

    rand_items = 0;
    for (int f = 0; rand_items < 150 || f < 8; f++) begin
      drain();
      if (f == 3) begin
        write_reg(REG_WIDTH, 60'd2047);
        write_reg(REG_HEIGHT, 60'd1);
      end else if (f == 6) begin
        write_reg(REG_WIDTH, 60'd0);
        write_reg(REG_HEIGHT, 60'd1024);
      end else if (f == 1) begin
        write_reg(REG_WIDTH, 60'd7);
        write_reg(REG_HEIGHT, 60'd5);
      end else begin
        write_reg(REG_WIDTH, 60'($urandom_range(1, 7)));
        write_reg(REG_HEIGHT, 60'($urandom_range(0, 5)));
      end
      write_reg(REG_KTOP, random_kernel_row());
      write_reg(REG_KMID, random_kernel_row());
      write_reg(REG_KBOT, random_kernel_row());
      quiet = ($urandom_range(0, 3) == 0);
      if (f == 1) hold_asks++;
      in_frame = 0;
      do begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, typed_res);
        rand_items++;
        in_frame++;
        w = eff_size(width_reg, MAXW);
        // Shrinking the frame in mid-stream never makes the line stores read
        // entries that were not written, so it is safe at any point.
        if ((f == 3 || f == 6) && in_frame == 10) begin
          drain();
          if (f == 3) write_reg(REG_WIDTH, 60'd12);
          else write_reg(REG_HEIGHT, 60'd12);
          n_shrinks++;
        end else if (f != 3 && f != 6 && (cur_col != 0 || cur_row != 0)
            && $urandom_range(0, 14) == 0) begin
          drain();
          write_reg(REG_WIDTH, 60'($urandom_range(1, w)));
          write_reg(REG_HEIGHT, 60'($urandom_range(1, 6)));
          n_shrinks++;
        end
      end while (cur_col != 0 || cur_row != 0);
      n_frames++;
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    $display("covered %0d pixels and %0d results over %0d random frames",
             n_items, n_results, n_frames);
    $display("with %0d mid-frame resizes, extreme sizes and kernels, and a long output hold",
             n_shrinks);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rcf_pkg.sv
sv/rcf_window.sv
sv/rcf_mac.sv
sv/rgb_conv3x3_filter.sv
tb/rgb_conv3x3_filter_tb.sv
